>>> sv/rrid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrid_pkg
// shared constants, codes and controller/datapath link types for the
// round-robin slot id allocator
// ----------------------------------------------------------------------------
package rrid_pkg;

    localparam int ID_W        = 5;
    localparam int ID_COUNT    = 2 ** ID_W;
    localparam int HANDLE_W    = 8;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 2;

    // slots checked per scan cycle
    localparam int SCAN_WIDTH  = 8;
    localparam int SCAN_STEPS  = ID_COUNT / SCAN_WIDTH;
    localparam int SCAN_CNT_W  = (SCAN_STEPS > 1) ? $clog2(SCAN_STEPS) : 1;

    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RESOLVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FREE    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_POOL_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_USED   = 2'd3;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic in_alloc;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

>>> sv/rrid_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrid_req_if
// request channel: action, slot id and pool handle with valid/ready
// ----------------------------------------------------------------------------
interface rrid_req_if;
    logic                          valid;
    logic                          ready;
    logic [rrid_pkg::ACTION_W-1:0] action;
    logic [rrid_pkg::ID_W-1:0]     slot_id;
    logic [rrid_pkg::HANDLE_W-1:0] pool_handle;
    logic                          pool_ok;

    modport source (output valid, action, slot_id, pool_handle, pool_ok, input ready);
    modport sink   (input valid, action, slot_id, pool_handle, pool_ok, output ready);
endinterface

>>> sv/rrid_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrid_rsp_if
// response channel: result id, handle and status with valid/ready
// ----------------------------------------------------------------------------
interface rrid_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rrid_pkg::ID_W-1:0]     result_id;
    logic [rrid_pkg::HANDLE_W-1:0] result_handle;
    logic [rrid_pkg::STATUS_W-1:0] status;

    modport source (output valid, result_id, result_handle, status, input ready);
    modport sink   (input valid, result_id, result_handle, status, output ready);
endinterface

>>> sv/rrid_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrid_ctrl
// sequencer: accepts one request, runs the free-slot scan for allocate,
// then commits the table update and the response
// ----------------------------------------------------------------------------
module rrid_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rrid_req_if.sink         i_req,
    input  rrid_pkg::t_sts   i_sts,
    output rrid_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        i_req.ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.in_alloc ? S_SCAN : S_RESP;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_hit || i_sts.scan_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // scan ends within the table size
    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && i_sts.scan_last |=> (r_state == S_RESP))
        else $error("scan ran past the last group");

    // a transfer in always leads to a response stage before the next one
    a_accept_to_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_SCAN) || (r_state == S_RESP))
        else $error("accepted request not processed");

    a_commit_only_in_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == S_IDLE))
        else $error("commit did not return to idle");

endmodule

>>> sv/rrid_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrid_dp
// slot table datapath: used bits, handle memory, round-robin pointer,
// eight-slot scan window and the response register
// ----------------------------------------------------------------------------
module rrid_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rrid_req_if.sink         i_req,
    rrid_rsp_if.source       o_rsp,
    input  rrid_pkg::t_cmd   i_cmd,
    output rrid_pkg::t_sts   o_sts
);

    localparam int ID_W     = rrid_pkg::ID_W;
    localparam int HANDLE_W = rrid_pkg::HANDLE_W;

    logic [rrid_pkg::ID_COUNT-1:0]     r_used;
    logic [rrid_pkg::ID_COUNT-1:0]     n_used;
    logic [ID_W-1:0]                   r_next;
    logic [ID_W-1:0]                   n_next;
    logic [HANDLE_W-1:0]               r_handle_mem [rrid_pkg::ID_COUNT];
    logic [HANDLE_W-1:0]               r_rd_data;

    logic [rrid_pkg::ACTION_W-1:0]     r_action;
    logic [ID_W-1:0]                   r_slot_id;
    logic [HANDLE_W-1:0]               r_pool_handle;
    logic                              r_pool_ok;

    logic [ID_W-1:0]                   r_scan_base;
    logic [rrid_pkg::SCAN_CNT_W-1:0]   r_scan_cnt;
    logic [ID_W-1:0]                   r_found;
    logic                              r_found_ok;

    logic                              r_out_valid;
    logic [ID_W-1:0]                   r_out_id;
    logic [HANDLE_W-1:0]               r_out_handle;
    logic [rrid_pkg::STATUS_W-1:0]     r_out_status;
    logic [ID_W-1:0]                   n_out_id;
    logic [HANDLE_W-1:0]               n_out_handle;
    logic [rrid_pkg::STATUS_W-1:0]     n_out_status;

    logic                              mem_we;
    logic                              scan_hit;
    logic [ID_W-1:0]                   scan_idx;

    // first free slot in the current window, in round-robin order
    always_comb begin
        logic [ID_W-1:0] idx;
        scan_hit = 1'b0;
        scan_idx = r_scan_base;
        for (int j = rrid_pkg::SCAN_WIDTH - 1; j >= 0; j--) begin
            idx = r_scan_base + ID_W'(j);
            if (!r_used[idx]) begin
                scan_hit = 1'b1;
                scan_idx = idx;
            end
        end
    end

    assign o_sts.in_alloc  = (i_req.action == rrid_pkg::ACT_ALLOC);
    assign o_sts.scan_hit  = scan_hit;
    assign o_sts.scan_last = (r_scan_cnt == rrid_pkg::SCAN_CNT_W'(rrid_pkg::SCAN_STEPS - 1));
    assign o_sts.out_free  = !r_out_valid || o_rsp.ready;

    // response and table update for the item in hand
    always_comb begin
        n_used       = r_used;
        n_next       = r_next;
        mem_we       = 1'b0;
        n_out_id     = r_slot_id;
        n_out_handle = '0;
        n_out_status = rrid_pkg::STATUS_NOT_USED;
        case (r_action)
            rrid_pkg::ACT_ALLOC: begin
                n_out_id = '0;
                if (!r_found_ok) begin
                    n_out_status = rrid_pkg::STATUS_TABLE_FULL;
                end else begin
                    n_next = r_found;
                    if (!r_pool_ok) begin
                        n_out_status = rrid_pkg::STATUS_POOL_EMPTY;
                    end else begin
                        n_used[r_found] = 1'b1;
                        mem_we          = 1'b1;
                        n_out_id        = r_found;
                        n_out_handle    = r_pool_handle;
                        n_out_status    = rrid_pkg::STATUS_OK;
                    end
                end
            end
            rrid_pkg::ACT_RESOLVE: begin
                if (r_used[r_slot_id]) begin
                    n_out_handle = r_rd_data;
                    n_out_status = rrid_pkg::STATUS_OK;
                end
            end
            rrid_pkg::ACT_FREE: begin
                if (r_used[r_slot_id]) begin
                    n_out_handle        = r_rd_data;
                    n_out_status        = rrid_pkg::STATUS_OK;
                    n_used[r_slot_id]   = 1'b0;
                    if (r_slot_id == r_next) begin
                        n_next = r_next + ID_W'(1);
                    end
                end
            end
            default: begin
                n_out_status = rrid_pkg::STATUS_NOT_USED;
            end
        endcase
    end

    // handle memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && mem_we) begin
            r_handle_mem[r_found] <= r_pool_handle;
        end
        if (i_cmd.accept) begin
            r_rd_data <= r_handle_mem[i_req.slot_id];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_next      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_used      <= n_used;
                r_next      <= n_next;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item, scan and response payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action      <= i_req.action;
            r_slot_id     <= i_req.slot_id;
            r_pool_handle <= i_req.pool_handle;
            r_pool_ok     <= i_req.pool_ok;
            r_scan_base   <= r_next;
            r_scan_cnt    <= '0;
            r_found_ok    <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_scan_base <= r_scan_base + ID_W'(rrid_pkg::SCAN_WIDTH);
            r_scan_cnt  <= r_scan_cnt + rrid_pkg::SCAN_CNT_W'(1);
            if (scan_hit) begin
                r_found    <= scan_idx;
                r_found_ok <= 1'b1;
            end
        end
        if (i_cmd.commit) begin
            r_out_id     <= n_out_id;
            r_out_handle <= n_out_handle;
            r_out_status <= n_out_status;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.result_id     = r_out_id;
    assign o_rsp.result_handle = r_out_handle;
    assign o_rsp.status        = r_out_status;

    a_commit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> o_sts.out_free)
        else $error("response overwritten before transfer");

    a_no_scan_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> !r_found_ok)
        else $error("scan continued after a free slot was found");

    a_alloc_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && (r_action == rrid_pkg::ACT_ALLOC) && r_found_ok && r_pool_ok
        |=> r_used[$past(r_found)] && (r_next == $past(r_found)))
        else $error("allocated slot not marked used");

    a_found_is_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && (r_action == rrid_pkg::ACT_ALLOC) && r_found_ok
        |-> !r_used[r_found])
        else $error("scan returned a used slot");

endmodule

>>> sv/round_robin_id_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_id_allocator
// hands out slot ids round-robin, stores a pool handle per id, resolves and
// frees ids
// ----------------------------------------------------------------------------
//  port    | dir | contents
//  i_req   | in  | action, slot_id, pool_handle, pool_ok
//  o_rsp   | out | result_id, result_handle, status
//
//  resolve and free go from transfer in through the response stage to the
//  registered response; allocate first runs the scan, which checks 8 slots
//  per cycle from the pointer over the 32-slot table
//  one request in flight; the next is taken once the response is registered
//  a stalled response holds the block in its response stage only when a
//  second response is ready
//  reset clears the used bits and the pointer directly; no clearing pass
// ----------------------------------------------------------------------------
module round_robin_id_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrid_req_if.sink    i_req,
    rrid_rsp_if.source  o_rsp
);

    rrid_pkg::t_cmd cmd;
    rrid_pkg::t_sts sts;

    rrid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rrid_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

>>> sim/rrid_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrid_alloc_checker
// watches the request and response channels of the id allocator, keeps its
// own copy of the slot table and the round-robin pointer, predicts the
// response of every request transfer and compares it field by field with
// the oldest prediction when the response transfer happens
// ----------------------------------------------------------------------------
module rrid_alloc_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrid_req_if        i_req,
    rrid_rsp_if        i_rsp,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int ID_W     = rrid_pkg::ID_W;
    localparam int ID_COUNT = rrid_pkg::ID_COUNT;
    localparam int HANDLE_W = rrid_pkg::HANDLE_W;
    localparam int ACTION_W = rrid_pkg::ACTION_W;
    localparam int STATUS_W = rrid_pkg::STATUS_W;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
        logic [STATUS_W-1:0] status;
    } t_slot_result;

    logic                slot_taken [ID_COUNT];
    logic [HANDLE_W-1:0] slot_value [ID_COUNT];
    logic [ID_W-1:0]     search_ptr;
    t_slot_result        expected_rsp_q [$];
    int                  fail_count = 0;
    int                  pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // updates the shadow table and returns the response the block owes
    function automatic t_slot_result apply_request(input logic [ACTION_W-1:0] act,
                                                   input logic [ID_W-1:0]     id,
                                                   input logic [HANDLE_W-1:0] handle,
                                                   input logic                ok);
        t_slot_result    res;
        logic [ID_W-1:0] idx;
        logic            found;
        res   = '{id: id, handle: '0, status: rrid_pkg::STATUS_NOT_USED};
        idx   = search_ptr;
        found = 1'b0;
        case (act)
            rrid_pkg::ACT_ALLOC: begin
                res.id = '0;
                for (int k = 0; k < ID_COUNT; k++) begin
                    if (!found) begin
                        if (!slot_taken[idx]) found = 1'b1;
                        else idx = idx + ID_W'(1);
                    end
                end
                if (!found) begin
                    res.status = rrid_pkg::STATUS_TABLE_FULL;
                end else begin
                    search_ptr = idx;
                    if (!ok) begin
                        res.status = rrid_pkg::STATUS_POOL_EMPTY;
                    end else begin
                        slot_taken[idx] = 1'b1;
                        slot_value[idx] = handle;
                        res = '{id: idx, handle: handle, status: rrid_pkg::STATUS_OK};
                    end
                end
            end
            rrid_pkg::ACT_RESOLVE: begin
                if (slot_taken[id]) begin
                    res.handle = slot_value[id];
                    res.status = rrid_pkg::STATUS_OK;
                end
            end
            rrid_pkg::ACT_FREE: begin
                if (slot_taken[id]) begin
                    res.handle     = slot_value[id];
                    res.status     = rrid_pkg::STATUS_OK;
                    slot_taken[id] = 1'b0;
                    if (id == search_ptr) search_ptr = search_ptr + ID_W'(1);
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_slot_result got;
        t_slot_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < ID_COUNT; k++) slot_taken[k] = 1'b0;
            search_ptr = '0;
            expected_rsp_q.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{id: i_rsp.result_id, handle: i_rsp.result_handle,
                        status: i_rsp.status};
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected response id %0d handle %0h status %0d",
                                              got.id, got.handle, got.status));
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (got.id !== want.id)
                        report_mismatch($sformatf("result_id got %0d want %0d",
                                                  got.id, want.id));
                    if (got.handle !== want.handle)
                        report_mismatch($sformatf("result_handle got %0h want %0h (id %0d)",
                                                  got.handle, want.handle, want.id));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d (id %0d)",
                                                  got.status, want.status, want.id));
                end
            end
            if (i_req.valid && i_req.ready)
                expected_rsp_q.push_back(apply_request(i_req.action, i_req.slot_id,
                                                       i_req.pool_handle, i_req.pool_ok));
        end
        pending_cnt <= expected_rsp_q.size();
    end

endmodule

>>> sim/tb_round_robin_id_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_id_allocator
// drives allocate, resolve, free and unknown requests into the id allocator
// with random gaps and response stalls, and gives the verdict from the
// failure count of the checker that runs beside the block
// ----------------------------------------------------------------------------
module tb_round_robin_id_allocator;

    localparam int ID_W     = rrid_pkg::ID_W;
    localparam int ID_COUNT = rrid_pkg::ID_COUNT;
    localparam int HANDLE_W = rrid_pkg::HANDLE_W;
    localparam int ACTION_W = rrid_pkg::ACTION_W;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 10;
    localparam int TOTAL_ITEMS  = 1850;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT_NS     = 4_000_000;

    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

    logic i_clk;
    logic i_rst_n;

    rrid_req_if req_if ();
    rrid_rsp_if rsp_if ();

    int                  fail_count;
    int                  pending;
    int                  sender_idle_pct;
    int                  receiver_idle_pct;
    int                  items_sent;
    int                  hold_left;
    logic                hold_toggle;
    logic                hold_seen;
    logic [ID_COUNT-1:0] ever_written;

    round_robin_id_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    rrid_alloc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        #(LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // response side, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_seen    <= 1'b0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen    <= hold_toggle;
            hold_left    <= LONG_HOLD;
            rsp_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // slots holding a handle at some point; only these are resolved or freed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ever_written <= '0;
        end else if (rsp_if.valid && rsp_if.ready && rsp_if.status == rrid_pkg::STATUS_OK) begin
            ever_written[rsp_if.result_id] <= 1'b1;
        end
    end

    function automatic logic [ID_W-1:0] pick_written_id();
        logic [ID_W-1:0] cand;
        cand = ID_W'($urandom_range(ID_COUNT - 1));
        for (int k = 0; k < ID_COUNT && !ever_written[cand]; k++) cand = cand + ID_W'(1);
        return cand;
    endfunction

    function automatic logic [ACTION_W-1:0] mixed_action();
        int r;
        r = $urandom_range(99);
        if (r < 35) return rrid_pkg::ACT_ALLOC;
        if (r < 70) return rrid_pkg::ACT_RESOLVE;
        if (r < 95) return rrid_pkg::ACT_FREE;
        return ACT_UNKNOWN;
    endfunction

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] id,
                             input logic [HANDLE_W-1:0] handle, input logic ok);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.action      <= act;
        req_if.slot_id     <= id;
        req_if.pool_handle <= handle;
        req_if.pool_ok     <= ok;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic send_action(input logic [ACTION_W-1:0] act, input int ok_pct);
        logic [ACTION_W-1:0] a;
        logic [ID_W-1:0]     id;
        a = act;
        if (a != rrid_pkg::ACT_ALLOC && ever_written == '0) a = rrid_pkg::ACT_ALLOC;
        id = (a == rrid_pkg::ACT_ALLOC) ? ID_W'($urandom) : pick_written_id();
        send_item(a, id, HANDLE_W'($urandom), $urandom_range(99) < ok_pct);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n_items);
        int stop_at;
        int kind;
        int len;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                // fill: a run of 30 to 40 allocations that can run the table full
                len = $urandom_range(40, 30);
                repeat (len) send_action(rrid_pkg::ACT_ALLOC, 90);
            end else if (kind < 50) begin
                len = $urandom_range(40, 16);
                repeat (len) send_action(rrid_pkg::ACT_FREE, 0);
            end else begin
                len = $urandom_range(24, 8);
                repeat (len) send_action(mixed_action(), 80);
            end
        end
    endtask

    initial begin
        int phase_items;
        req_if.valid       <= 1'b0;
        req_if.action      <= rrid_pkg::ACT_ALLOC;
        req_if.slot_id     <= '0;
        req_if.pool_handle <= '0;
        req_if.pool_ok     <= 1'b0;
        i_rst_n            <= 1'b0;
        hold_toggle        <= 1'b0;
        receiver_idle_pct  <= 59;
        sender_idle_pct    = 19;
        items_sent         = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pool empty, handle extremes, pointer stepping past a freed id
        send_item(rrid_pkg::ACT_ALLOC,   5'd31, 8'hAA, 1'b0);
        send_item(rrid_pkg::ACT_ALLOC,   5'd0,  8'hFF, 1'b1);
        send_item(rrid_pkg::ACT_ALLOC,   5'd31, 8'h00, 1'b1);
        send_item(ACT_UNKNOWN,           5'd0,  8'hFF, 1'b1);
        send_item(rrid_pkg::ACT_RESOLVE, 5'd0,  8'h00, 1'b0);
        send_item(rrid_pkg::ACT_RESOLVE, 5'd1,  8'hFF, 1'b1);
        send_item(rrid_pkg::ACT_FREE,    5'd1,  8'h00, 1'b0);
        send_item(rrid_pkg::ACT_RESOLVE, 5'd1,  8'h00, 1'b0);
        send_item(rrid_pkg::ACT_FREE,    5'd1,  8'hFF, 1'b1);
        send_item(rrid_pkg::ACT_ALLOC,   5'd1,  8'h5A, 1'b1);
        send_item(rrid_pkg::ACT_FREE,    5'd0,  8'h00, 1'b0);
        send_item(rrid_pkg::ACT_ALLOC,   5'd0,  8'h11, 1'b0);
        send_item(rrid_pkg::ACT_ALLOC,   5'd0,  8'h33, 1'b1);
        send_item(ACT_UNKNOWN,           5'd3,  8'h00, 1'b0);
        wait_drained();

        phase_items = (TOTAL_ITEMS - items_sent) / 3;
        run_phase(phase_items);
        wait_drained();

        sender_idle_pct   = 59;
        receiver_idle_pct <= 19;
        run_phase(phase_items);
        wait_drained();

        sender_idle_pct   = 0;
        receiver_idle_pct <= 0;
        hold_toggle       <= ~hold_toggle;
        run_phase(phase_items);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
